// ===== design/mbep_pkg.sv =====
package mbep_pkg;

  // Block sizing.
  localparam int unsigned DIGEST_BYTES = 32;
  localparam int unsigned MAX_MULT     = 9;
  localparam int unsigned BB_MAX       = MAX_MULT * DIGEST_BYTES;
  localparam int unsigned BB_W         = $clog2(BB_MAX + 1);
  localparam int unsigned MULT_W       = $clog2(MAX_MULT + 1);
  localparam int unsigned FILL_W       = 9;
  localparam int unsigned CMP_W        = (BB_W > FILL_W) ? BB_W : FILL_W;

  // Register reset values.
  localparam logic [7:0] MASK_RESET = 8'b1001_1111;
  localparam logic [3:0] MULT_RESET = 4'd4;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CHANNEL_MASK = 2'd0,
    REG_BLOCK_MULT   = 2'd1,
    REG_RAW_MODE     = 2'd2
  } reg_idx_e;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_TAKE    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  // Classified item handed from the front to the back.
  typedef struct packed {
    cmd_e       op;
    logic [7:0] ext;
    logic [3:0] nbits;
  } cmd_rec_t;

  // One packed result.
  typedef struct packed {
    logic [7:0]        data_byte;
    logic [FILL_W-1:0] byte_index;
    logic              buffer_select;
    logic              block_end;
    logic              dropped;
  } out_rec_t;

  // Block size settings seen by the back end.
  typedef struct packed {
    logic [3:0] block_mult;
    logic       raw_mode;
  } blk_cfg_t;

endpackage

// ===== design/mbep_fifo.sv =====
module mbep_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage slots need no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue occupancy above depth");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o && !pop_i) |=> !empty_o)
    else $error("queue empty after a lone push");

  a_last_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !push_i && count_q == CNT_W'(1)) |=> empty_o)
    else $error("queue not empty after popping the last entry");
`endif

endmodule

// ===== design/mbep_front.sv =====
module mbep_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          cmd_i,
  input  logic [7:0]          sample_i,
  input  logic [7:0]          channel_mask_i,
  output logic                q_push_o,
  output mbep_pkg::cmd_rec_t  q_rec_o,
  input  logic                q_full_i
);

  logic [7:0] ext;
  logic [3:0] nbits;

  // Parallel bit extract: selected sample bits packed toward bit 0.
  always_comb begin
    ext   = '0;
    nbits = '0;
    for (int i = 0; i < 8; i++) begin
      if (channel_mask_i[i]) begin
        ext[nbits[2:0]] = sample_i[i];
        nbits           = nbits + 4'd1;
      end
    end
  end

  // Classify the command and hand the item to the queue.
  assign full             = q_full_i;
  assign q_push_o         = push && !q_full_i;
  assign q_rec_o.op       = mbep_pkg::cmd_e'(cmd_i);
  assign q_rec_o.ext      = (cmd_i == mbep_pkg::CMD_SAMPLE) ? ext : '0;
  assign q_rec_o.nbits    = (cmd_i == mbep_pkg::CMD_SAMPLE) ? nbits : '0;

`ifndef SYNTHESIS
  a_nbits_popcount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == mbep_pkg::CMD_SAMPLE) |-> nbits == 4'($countones(channel_mask_i)))
    else $error("extracted bit count differs from mask popcount");

  a_ext_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nbits < 4'd8) |-> ((ext >> nbits[2:0]) == 8'd0))
    else $error("extracted bits above the selected count");

  a_push_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> push && !full)
    else $error("queue written without an accepted transfer");
`endif

endmodule

// ===== design/mbep_back.sv =====
module mbep_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbep_pkg::blk_cfg_t  cfg_i,
  input  logic                q_empty_i,
  input  mbep_pkg::cmd_rec_t  q_rec_i,
  output logic                q_pop_o,
  input  logic                out_full_i,
  output logic                out_push_o,
  output mbep_pkg::out_rec_t  out_rec_o
);

  localparam int unsigned FW = mbep_pkg::FILL_W;
  localparam int unsigned CW = mbep_pkg::CMP_W;
  localparam int unsigned BW = mbep_pkg::BB_W;
  localparam int unsigned MW = mbep_pkg::MULT_W;

  logic [14:0]   acc_q, acc_d;
  logic [3:0]    cnt_q, cnt_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          active_q, active_d;
  logic          ready_q, ready_d;

  logic [14:0]   acc_sum;
  logic [3:0]    cnt_sum;
  logic [FW-1:0] fill_nxt;
  logic [MW-1:0] mult_eff;
  logic [BW-1:0] block_bytes;
  logic          is_sample, emit, blk_end, advance;

  // Block size from the current settings, multiplicity clamped to its range.
  always_comb begin
    if (cfg_i.block_mult == 4'd0) begin
      mult_eff = MW'(1);
    end else if ({1'b0, cfg_i.block_mult} > 5'(mbep_pkg::MAX_MULT)) begin
      mult_eff = MW'(mbep_pkg::MAX_MULT);
    end else begin
      mult_eff = MW'(cfg_i.block_mult);
    end
    if (cfg_i.raw_mode) begin
      block_bytes = BW'(mbep_pkg::DIGEST_BYTES);
    end else begin
      block_bytes = BW'(BW'(mult_eff) * BW'(mbep_pkg::DIGEST_BYTES));
    end
  end

  // Accumulate the extracted bits and decide whether a byte leaves.
  assign is_sample = (q_rec_i.op == mbep_pkg::CMD_SAMPLE);
  assign acc_sum   = acc_q | 15'({15'd0, q_rec_i.ext} << cnt_q);
  assign cnt_sum   = cnt_q + q_rec_i.nbits;
  assign emit      = is_sample && cnt_sum[3];
  assign fill_nxt  = fill_q + 1'b1;
  assign blk_end   = (fill_nxt == '0) || (CW'(fill_nxt) >= CW'(block_bytes));
  assign advance   = !q_empty_i && (!emit || !out_full_i);
  assign q_pop_o   = advance;
  assign out_push_o = advance && emit;

  assign out_rec_o.data_byte     = acc_sum[7:0];
  assign out_rec_o.byte_index    = fill_q;
  assign out_rec_o.buffer_select = active_q;
  assign out_rec_o.block_end     = blk_end;
  assign out_rec_o.dropped       = blk_end && ready_q;

  // Next collector state per command.
  always_comb begin
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    fill_d   = fill_q;
    active_d = active_q;
    ready_d  = ready_q;
    if (advance) begin
      unique case (q_rec_i.op)
        mbep_pkg::CMD_SAMPLE: begin
          if (emit) begin
            acc_d = {8'd0, acc_sum[14:8]};
            cnt_d = cnt_sum - 4'd8;
            if (blk_end) begin
              fill_d   = '0;
              ready_d  = 1'b1;
              active_d = !active_q;
            end else begin
              fill_d = fill_nxt;
            end
          end else begin
            acc_d = acc_sum;
            cnt_d = cnt_sum;
          end
        end
        mbep_pkg::CMD_TAKE: begin
          ready_d = 1'b0;
        end
        mbep_pkg::CMD_RESTART: begin
          acc_d    = '0;
          cnt_d    = '0;
          fill_d   = '0;
          ready_d  = 1'b0;
          active_d = !active_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      cnt_q    <= '0;
      fill_q   <= '0;
      active_q <= 1'b0;
      ready_q  <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      fill_q   <= fill_d;
      active_q <= active_d;
      ready_q  <= ready_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < 4'd8)
    else $error("bit count left at eight or more between items");

  a_end_clears_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push_o && blk_end) |=> (fill_q == '0) && ready_q)
    else $error("block end did not reset the fill count or mark ready");

  a_end_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push_o && blk_end) |=> (active_q != $past(active_q)))
    else $error("buffer select did not toggle at block end");
`endif

endmodule

// ===== design/masked_bit_extract_byte_packer.sv =====
// Masked bit extract and byte packer.
// Input channel: a queue write port. An item (cmd_i, sample_i) transfers at a
// rising edge with push high and full low. A sample keeps the bits picked by
// the channel mask, packed toward bit 0, and adds them to a bit accumulator;
// the take and restart commands only update the collector state.
// Result channel: a queue read port. While empty is low the oldest packed byte
// and its block position are on the result ports; it transfers at a rising
// edge with pop high. At most one result follows from each item.
// A sample is registered in the command queue and its result in the result queue before it reaches the ports.
// Throughput: one item per cycle while the result queue has room, set by the
// accumulate step in the back end; a two-entry queue sits on each side of that step.
// Stalls: if pop stays low the result queue fills, the back end holds, the
// command queue fills and full rises; items causing no result still need
// room in the command queue.
// Configuration: write enable, index and data; a write takes effect at the next
// edge. The user makes a write only while the block is idle; the block does not enforce it.
// Reset: the control and configuration registers return to their defaults, both queues empty.
module masked_bit_extract_byte_packer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [1:0] cmd_i,
  input  logic [7:0] sample_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte_o,
  output logic [8:0] byte_index_o,
  output logic       buffer_select_o,
  output logic       block_end_o,
  output logic       dropped_o
);

  logic [7:0]         mask_q;
  logic [3:0]         mult_q;
  logic               raw_q;
  mbep_pkg::blk_cfg_t blk_cfg;

  logic               cq_push, cq_full, cq_empty, cq_pop;
  mbep_pkg::cmd_rec_t cq_in, cq_out;
  logic               oq_push, oq_full;
  mbep_pkg::out_rec_t oq_in, oq_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= mbep_pkg::MASK_RESET;
      mult_q <= mbep_pkg::MULT_RESET;
      raw_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (mbep_pkg::reg_idx_e'(cfg_index_i))
        mbep_pkg::REG_CHANNEL_MASK: mask_q <= cfg_data_i;
        mbep_pkg::REG_BLOCK_MULT:   mult_q <= cfg_data_i[3:0];
        mbep_pkg::REG_RAW_MODE:     raw_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign blk_cfg.block_mult = mult_q;
  assign blk_cfg.raw_mode   = raw_q;

  // Front end: accept and extract.
  mbep_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .cmd_i          (cmd_i),
    .sample_i       (sample_i),
    .channel_mask_i (mask_q),
    .q_push_o       (cq_push),
    .q_rec_o        (cq_in),
    .q_full_i       (cq_full)
  );

  // Command queue between front and back.
  mbep_fifo #(
    .WIDTH ($bits(mbep_pkg::cmd_rec_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .data_i  (cq_in),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .data_o  (cq_out),
    .empty_o (cq_empty)
  );

  // Back end: accumulate and pack bytes.
  mbep_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (blk_cfg),
    .q_empty_i  (cq_empty),
    .q_rec_i    (cq_out),
    .q_pop_o    (cq_pop),
    .out_full_i (oq_full),
    .out_push_o (oq_push),
    .out_rec_o  (oq_in)
  );

  // Result queue toward the consumer.
  mbep_fifo #(
    .WIDTH ($bits(mbep_pkg::out_rec_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .data_i  (oq_in),
    .full_o  (oq_full),
    .pop_i   (pop),
    .data_o  (oq_out),
    .empty_o (empty)
  );

  assign data_byte_o     = oq_out.data_byte;
  assign byte_index_o    = oq_out.byte_index;
  assign buffer_select_o = oq_out.buffer_select;
  assign block_end_o     = oq_out.block_end;
  assign dropped_o       = oq_out.dropped;

`ifndef SYNTHESIS
  a_drop_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && dropped_o) |-> block_end_o)
    else $error("drop flag on a byte that does not end a block");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (10'(byte_index_o) < 10'(mbep_pkg::BB_MAX) || raw_q == 1'b0))
    else $error("byte index beyond the largest block");

  a_no_result_unmasked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_q == 8'd0 && cq_empty && empty) |=> empty)
    else $error("result produced with an empty channel mask");
`endif

endmodule

// ===== sim/tb_masked_bit_extract_byte_packer.sv =====
// Tracks the collector state and keeps the bytes the packer still owes.
class packed_byte_ledger;
  logic [7:0]         mask;
  logic [3:0]         mult;
  logic               raw;
  logic [14:0]        acc;
  logic [3:0]         nbits;
  logic [8:0]         fill;
  logic               buf_sel;
  logic               ready;
  mbep_pkg::out_rec_t bytes_due[$];
  int unsigned        items;
  int unsigned        bytes_checked;
  int unsigned        ends_seen;
  int unsigned        drops_seen;
  int unsigned        mismatches;

  function new();
    mask          = mbep_pkg::MASK_RESET;
    mult          = mbep_pkg::MULT_RESET;
    raw           = 1'b0;
    acc           = '0;
    nbits         = '0;
    fill          = '0;
    buf_sel       = 1'b0;
    ready         = 1'b0;
    items         = 0;
    bytes_checked = 0;
    ends_seen     = 0;
    drops_seen    = 0;
    mismatches    = 0;
  endfunction

  function void set_reg(mbep_pkg::reg_idx_e idx, logic [7:0] val);
    case (idx)
      mbep_pkg::REG_CHANNEL_MASK: mask = val;
      mbep_pkg::REG_BLOCK_MULT:   mult = val[3:0];
      mbep_pkg::REG_RAW_MODE:     raw  = val[0];
      default: ;
    endcase
  endfunction

  // Raw mode forces one digest; otherwise the multiplicity is clamped to 1..MAX_MULT.
  function int unsigned block_len();
    int unsigned m;
    if (raw) return mbep_pkg::DIGEST_BYTES;
    m = mult;
    if (m < 1) m = 1;
    if (m > mbep_pkg::MAX_MULT) m = mbep_pkg::MAX_MULT;
    return m * mbep_pkg::DIGEST_BYTES;
  endfunction

  // Called once per input transfer; queues the byte it produces, if any.
  function void absorb_item(mbep_pkg::cmd_e op, logic [7:0] smp);
    logic [7:0]         picked;
    logic [3:0]         kept;
    logic [8:0]         next_fill;
    mbep_pkg::out_rec_t r;
    items++;
    case (op)
      mbep_pkg::CMD_TAKE: ready = 1'b0;
      mbep_pkg::CMD_RESTART: begin
        acc     = '0;
        nbits   = '0;
        fill    = '0;
        ready   = 1'b0;
        buf_sel = ~buf_sel;
      end
      mbep_pkg::CMD_SAMPLE: begin
        // Compact the masked sample bits toward bit 0.
        picked = '0;
        kept   = '0;
        for (int b = 0; b < 8; b++) begin
          if (mask[b]) begin
            picked[kept[2:0]] = smp[b];
            kept++;
          end
        end
        acc   = acc | (15'(picked) << nbits);
        nbits = nbits + kept;
        if (nbits >= 4'd8) begin
          r.data_byte     = acc[7:0];
          r.byte_index    = fill;
          r.buffer_select = buf_sel;
          acc             = acc >> 8;
          nbits           = nbits - 4'd8;
          // The block size is re-read at every byte, so a shrink ends the block at once.
          next_fill = fill + 9'd1;
          if (next_fill == '0 || next_fill >= block_len()) begin
            r.block_end = 1'b1;
            r.dropped   = ready;
            ready       = 1'b1;
            buf_sel     = ~buf_sel;
            fill        = '0;
          end else begin
            r.block_end = 1'b0;
            r.dropped   = 1'b0;
            fill        = next_fill;
          end
          bytes_due.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  // Compares one result transfer against the oldest owed byte.
  function void match_byte(logic [7:0] d, logic [8:0] idx, logic bsel, logic bend,
                           logic drp);
    mbep_pkg::out_rec_t want;
    if (bytes_due.size() == 0) begin
      note_mismatch($sformatf("unexpected byte %02h index %0d buf %0b end %0b drop %0b",
                              d, idx, bsel, bend, drp));
      return;
    end
    want = bytes_due.pop_front();
    bytes_checked++;
    if (want.block_end) ends_seen++;
    if (want.dropped) drops_seen++;
    if (d !== want.data_byte || idx !== want.byte_index || bsel !== want.buffer_select ||
        bend !== want.block_end || drp !== want.dropped)
      note_mismatch($sformatf(
        "expected data %02h index %0d buf %0b end %0b drop %0b, got %02h %0d %0b %0b %0b",
        want.data_byte, want.byte_index, want.buffer_select, want.block_end, want.dropped,
        d, idx, bsel, bend, drp));
  endfunction

  function void close_out();
    if (bytes_due.size() != 0)
      note_mismatch($sformatf("%0d expected bytes never arrived", bytes_due.size()));
  endfunction
endclass

module tb_masked_bit_extract_byte_packer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HALF_PERIOD      = 6;
  localparam int unsigned RESET_CYCLES     = 7;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS      = 110;
  localparam int unsigned CYCLE_LIMIT      = 150000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       push;
  logic       full;
  logic [1:0] cmd_in;
  logic [7:0] sample_in;
  logic       empty;
  logic       pop;
  logic [7:0] data_byte;
  logic [8:0] byte_index;
  logic       buffer_select;
  logic       block_end;
  logic       dropped;

  bit          steady        = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned cycle_count   = 0;

  packed_byte_ledger ledger = new();

  masked_bit_extract_byte_packer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .push            (push),
    .full            (full),
    .cmd_i           (cmd_in),
    .sample_i        (sample_in),
    .empty           (empty),
    .pop             (pop),
    .data_byte_o     (data_byte),
    .byte_index_o    (byte_index),
    .buffer_select_o (buffer_select),
    .block_end_o     (block_end),
    .dropped_o       (dropped)
  );

  initial clk_i = 1'b0;
  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Every result transfer is checked at the edge that completes it.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      ledger.match_byte(data_byte, byte_index, buffer_select, block_end, dropped);
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned gap;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        pop <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 12);
        pop <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic write_reg(input mbep_pkg::reg_idx_e idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    ledger.set_reg(idx, val);
  endtask

  task automatic configure(input logic [7:0] m, input logic [3:0] mu, input logic r);
    write_reg(mbep_pkg::REG_CHANNEL_MASK, m);
    write_reg(mbep_pkg::REG_BLOCK_MULT, {4'b0, mu});
    write_reg(mbep_pkg::REG_RAW_MODE, {7'b0, r});
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Offers one item and returns at the edge where its transfer happens.
  task automatic send_item(input mbep_pkg::cmd_e op, input logic [7:0] smp);
    @(negedge clk_i);
    push      <= 1'b1;
    cmd_in    <= op;
    sample_in <= smp;
    do @(posedge clk_i); while (full);
    ledger.absorb_item(op, smp);
  endtask

  task automatic idle_sender(input int unsigned n);
    @(negedge clk_i);
    push <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Stops input and waits until every owed byte has come and the pipe is quiet.
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (ledger.bytes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly samples; rare restarts keep blocks long enough to complete.
  task automatic run_random(input int unsigned count, input int unsigned take_pct,
                            input bit gaps);
    int unsigned    roll;
    mbep_pkg::cmd_e op;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 1) op = mbep_pkg::CMD_RESTART;
      else if (roll < 3) op = mbep_pkg::CMD_UNUSED;
      else if (roll < 3 + take_pct) op = mbep_pkg::CMD_TAKE;
      else op = mbep_pkg::CMD_SAMPLE;
      send_item(op, 8'($urandom));
      if (gaps && $urandom_range(0, 7) == 0) idle_sender($urandom_range(1, 12));
    end
  endtask

  initial begin : stimulus
    logic [7:0] rnd_mask;
    logic [3:0] rnd_mult;
    logic       rnd_raw;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = mbep_pkg::REG_CHANNEL_MASK;
    cfg_data  = '0;
    push      = 1'b0;
    cmd_in    = mbep_pkg::CMD_SAMPLE;
    sample_in = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Full mask with multiplicity zero: every sample is one byte, blocks of one digest.
    configure(8'hFF, 4'd0, 1'b0);
    send_item(mbep_pkg::CMD_SAMPLE, 8'h00);
    send_item(mbep_pkg::CMD_SAMPLE, 8'hFF);
    send_item(mbep_pkg::CMD_SAMPLE, 8'hA5);
    send_item(mbep_pkg::CMD_SAMPLE, 8'h5A);
    send_item(mbep_pkg::CMD_SAMPLE, 8'h01);
    send_item(mbep_pkg::CMD_SAMPLE, 8'h80);
    send_item(mbep_pkg::CMD_TAKE, 8'h00);
    send_item(mbep_pkg::CMD_UNUSED, 8'hFF);
    send_item(mbep_pkg::CMD_RESTART, 8'h00);
    send_item(mbep_pkg::CMD_SAMPLE, 8'h3C);
    settle();

    // Empty mask never produces a byte; multiplicity above the maximum.
    configure(8'h00, 4'd15, 1'b0);
    send_item(mbep_pkg::CMD_SAMPLE, 8'hFF);
    send_item(mbep_pkg::CMD_SAMPLE, 8'h00);
    send_item(mbep_pkg::CMD_TAKE, 8'hFF);
    settle();

    // Default channel mask in raw mode: bytes straddle sample boundaries.
    configure(mbep_pkg::MASK_RESET, 4'd9, 1'b1);
    send_item(mbep_pkg::CMD_SAMPLE, 8'hFF);
    send_item(mbep_pkg::CMD_SAMPLE, 8'h00);
    send_item(mbep_pkg::CMD_SAMPLE, 8'h7E);
    send_item(mbep_pkg::CMD_SAMPLE, 8'h81);
    send_item(mbep_pkg::CMD_SAMPLE, 8'hFF);
    send_item(mbep_pkg::CMD_SAMPLE, 8'h40);
    send_item(mbep_pkg::CMD_SAMPLE, 8'h20);
    settle();

    // Random phases; the block fill carries over each configuration change.
    for (int p = 0; p < 8; p++) begin
      rnd_mask = 8'($urandom);
      rnd_mult = 4'($urandom_range(0, 15));
      rnd_raw  = 1'($urandom_range(0, 1));
      case (p)
        0: configure(8'hFF, 4'd1, 1'b0);
        1: configure(8'hFF, 4'd9, 1'b0);
        2: configure(rnd_mask | 8'h81, 4'd2, 1'b0);
        3: configure(8'h01, 4'd15, 1'b1);
        7: configure(8'hFF, 4'd0, 1'b1);
        default: configure(rnd_mask, rnd_mult, rnd_raw);
      endcase
      if (p == 0) long_hold_req = 1'b1;
      steady = (p == 7);
      run_random(PHASE_ITEMS, (p % 2 == 0) ? 1 : 8, !(p == 0 || steady));
      settle();
    end

    ledger.close_out();
    $display("Run covered %0d input transfers and %0d checked bytes.",
             ledger.items, ledger.bytes_checked);
    $display("Blocks completed: %0d, of which %0d reported a dropped block; mismatches: %0d.",
             ledger.ends_seen, ledger.drops_seen, ledger.mismatches);
    if (ledger.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
